>>> hw/rtl/tof_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tof_pkg: shared types and constants of the triangle frame core
// fixed-point widths of every datapath step, stage counts, stage structs
// ----------------------------------------------------------------------------
package tof_pkg;

  // input coordinates, signed Q8.8
  localparam int COORD_W   = 16;
  // unit components, signed Q1.14
  localparam int UNIT_FRAC = 14;
  localparam int UNIT_W    = UNIT_FRAC + 2;
  localparam int UNIT_ONE  = 1 << UNIT_FRAC;

  // stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = ((9 * COORD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((9 * UNIT_W + 7) / 8) * 8;

  // cross product datapath
  localparam int EDGE_W   = COORD_W + 1;      // corner differences
  localparam int PROD_N_W = 2 * EDGE_W;       // e * t terms
  localparam int NRM_W    = PROD_N_W + 1;     // e x t
  localparam int PROD_B_W = EDGE_W + NRM_W;   // e * n terms
  localparam int VEC_W    = PROD_B_W + 1;     // e x n, widest vector

  // normalizer datapath
  localparam int MAG_W    = VEC_W;
  localparam int POS_W    = $clog2(MAG_W);
  localparam int SCL_TOP  = 23;               // leading one lands here
  localparam int SCL_W    = SCL_TOP + 1;
  localparam int SQ_W     = 2 * SCL_W;
  localparam int SUM_W    = SQ_W + 2;
  localparam int RAD_SH   = 12;
  localparam int RAD_W    = SUM_W + RAD_SH;   // radicand of the root
  localparam int ACC_W    = RAD_W + 1;        // root accumulator
  localparam int ROOT_W   = RAD_W / 2;
  localparam int SQRT_STEPS = RAD_W / 2;
  localparam int NUM_SH   = UNIT_FRAC + 6;
  localparam int NUM_W    = SCL_W + NUM_SH + 1;
  localparam int QUO_W    = UNIT_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int DSH_W    = ROOT_W + QUO_W - 1;

  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic signed [EDGE_W-1:0]   edge_t;
  typedef logic signed [PROD_N_W-1:0] prod_n_t;
  typedef logic signed [NRM_W-1:0]    nrm_t;
  typedef logic signed [PROD_B_W-1:0] prod_b_t;
  typedef logic signed [VEC_W-1:0]    vec_comp_t;
  typedef logic signed [UNIT_W-1:0]   unit_t;

  // per-vector sideband: component signs and zero-vector flag
  typedef struct packed {
    logic [2:0] sgn;
    logic       zero;
  } side_t;

  // one square root stage
  typedef struct packed {
    logic [RAD_W-1:0]            rem;
    logic [ACC_W-1:0]            root;
    logic [2:0][SCL_W-1:0]       mag;
    side_t                       side;
  } sqrt_stg_t;

  // one divider stage, three lanes sharing the divisor
  typedef struct packed {
    logic [2:0][NUM_W-1:0]       rem;
    logic [2:0][QUO_W-1:0]       quo;
    logic [ROOT_W-1:0]           den;
    side_t                       side;
  } div_stg_t;

endpackage
`default_nettype wire

>>> hw/rtl/tof_cross.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tof_cross: edge vectors and the two cross products
// five stages: differences, e*t terms, n, e*n terms, b
// ----------------------------------------------------------------------------
module tof_cross (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_vld,
  input  wire tof_pkg::coord_t c0 [3],
  input  wire tof_pkg::coord_t c1 [3],
  input  wire tof_pkg::coord_t c2 [3],
  output logic                 out_vld,
  output tof_pkg::edge_t       e_out [3],
  output tof_pkg::nrm_t        n_out [3],
  output tof_pkg::vec_comp_t   b_out [3]
);
  import tof_pkg::*;

  logic [4:0] vld_r;
  edge_t      e1_r [3], t1_r [3];
  prod_n_t    pn2_r [6];
  edge_t      e2_r [3];
  nrm_t       n3_r [3];
  edge_t      e3_r [3];
  prod_b_t    pb4_r [6];
  edge_t      e4_r [3];
  nrm_t       n4_r [3];
  vec_comp_t  b5_r [3];
  edge_t      e5_r [3];
  nrm_t       n5_r [3];

  edge_t      e1_nxt [3], t1_nxt [3];
  prod_n_t    pn2_nxt [6];
  nrm_t       n3_nxt [3];
  prod_b_t    pb4_nxt [6];
  vec_comp_t  b5_nxt [3];

  // corner differences
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_nxt[i] = EDGE_W'(c1[i]) - EDGE_W'(c0[i]);
      t1_nxt[i] = EDGE_W'(c2[i]) - EDGE_W'(c0[i]);
    end
  end

  // terms of e x t
  always_comb begin
    pn2_nxt[0] = PROD_N_W'(e1_r[1]) * PROD_N_W'(t1_r[2]);
    pn2_nxt[1] = PROD_N_W'(e1_r[2]) * PROD_N_W'(t1_r[1]);
    pn2_nxt[2] = PROD_N_W'(e1_r[2]) * PROD_N_W'(t1_r[0]);
    pn2_nxt[3] = PROD_N_W'(e1_r[0]) * PROD_N_W'(t1_r[2]);
    pn2_nxt[4] = PROD_N_W'(e1_r[0]) * PROD_N_W'(t1_r[1]);
    pn2_nxt[5] = PROD_N_W'(e1_r[1]) * PROD_N_W'(t1_r[0]);
  end

  // face normal direction
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n3_nxt[i] = NRM_W'(pn2_r[2*i]) - NRM_W'(pn2_r[2*i+1]);
    end
  end

  // terms of e x n
  always_comb begin
    pb4_nxt[0] = PROD_B_W'(e3_r[1]) * PROD_B_W'(n3_r[2]);
    pb4_nxt[1] = PROD_B_W'(e3_r[2]) * PROD_B_W'(n3_r[1]);
    pb4_nxt[2] = PROD_B_W'(e3_r[2]) * PROD_B_W'(n3_r[0]);
    pb4_nxt[3] = PROD_B_W'(e3_r[0]) * PROD_B_W'(n3_r[2]);
    pb4_nxt[4] = PROD_B_W'(e3_r[0]) * PROD_B_W'(n3_r[1]);
    pb4_nxt[5] = PROD_B_W'(e3_r[1]) * PROD_B_W'(n3_r[0]);
  end

  // in-plane perpendicular direction
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b5_nxt[i] = VEC_W'(pb4_r[2*i]) - VEC_W'(pb4_r[2*i+1]);
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_vld};
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      e1_r  <= e1_nxt;
      t1_r  <= t1_nxt;
      pn2_r <= pn2_nxt;
      e2_r  <= e1_r;
      n3_r  <= n3_nxt;
      e3_r  <= e2_r;
      pb4_r <= pb4_nxt;
      e4_r  <= e3_r;
      n4_r  <= n3_r;
      b5_r  <= b5_nxt;
      e5_r  <= e4_r;
      n5_r  <= n4_r;
    end
  end

  assign out_vld = vld_r[4];
  assign e_out   = e5_r;
  assign n_out   = n5_r;
  assign b_out   = b5_r;

endmodule
`default_nettype wire

>>> hw/rtl/tof_sqrt_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tof_sqrt_pipe: pipelined integer square root
// one result bit per stage, digit-by-digit, magnitudes ride along
// ----------------------------------------------------------------------------
module tof_sqrt_pipe (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_vld,
  input  wire tof_pkg::sqrt_stg_t in_stg,
  output logic                    out_vld,
  output tof_pkg::sqrt_stg_t      out_stg
);
  import tof_pkg::*;

  logic [SQRT_STEPS-1:0] vld_r;
  sqrt_stg_t             stg_r   [SQRT_STEPS];
  sqrt_stg_t             stg_nxt [SQRT_STEPS];
  sqrt_stg_t             src     [SQRT_STEPS];

  assign src[0] = in_stg;
  for (genvar k = 1; k < SQRT_STEPS; k++) begin : g_link
    assign src[k] = stg_r[k-1];
  end

  // one trial subtraction per stage
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    localparam logic [ACC_W-1:0] STEP_BIT = ACC_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [ACC_W:0] trial;
    always_comb begin
      trial      = {1'b0, src[k].root} + {1'b0, STEP_BIT};
      stg_nxt[k] = src[k];
      if ({2'b00, src[k].rem} >= trial) begin
        stg_nxt[k].rem  = src[k].rem - RAD_W'(trial);
        stg_nxt[k].root = (src[k].root >> 1) + STEP_BIT;
      end else begin
        stg_nxt[k].root = src[k].root >> 1;
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQRT_STEPS-2:0], in_vld};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      stg_r <= stg_nxt;
    end
  end

  assign out_vld = vld_r[SQRT_STEPS-1];
  assign out_stg = stg_r[SQRT_STEPS-1];

endmodule
`default_nettype wire

>>> hw/rtl/tof_div_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tof_div_pipe: pipelined restoring divider, three lanes
// one quotient bit per stage, the three components share the divisor
// ----------------------------------------------------------------------------
module tof_div_pipe (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_vld,
  input  wire tof_pkg::div_stg_t in_stg,
  output logic                   out_vld,
  output tof_pkg::div_stg_t      out_stg
);
  import tof_pkg::*;

  logic [DIV_STEPS-1:0] vld_r;
  div_stg_t             stg_r   [DIV_STEPS];
  div_stg_t             stg_nxt [DIV_STEPS];
  div_stg_t             src     [DIV_STEPS];

  assign src[0] = in_stg;
  for (genvar k = 1; k < DIV_STEPS; k++) begin : g_link
    assign src[k] = stg_r[k-1];
  end

  // compare and subtract the shifted divisor in every lane
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int QB = QUO_W - 1 - k;
    logic [DSH_W-1:0] dsh;
    always_comb begin
      dsh        = DSH_W'(src[k].den) << QB;
      stg_nxt[k] = src[k];
      for (int j = 0; j < 3; j++) begin
        if ({1'b0, src[k].rem[j]} >= dsh) begin
          stg_nxt[k].rem[j]     = src[k].rem[j] - NUM_W'(dsh);
          stg_nxt[k].quo[j][QB] = 1'b1;
        end
      end
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIV_STEPS-2:0], in_vld};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      stg_r <= stg_nxt;
    end
  end

  assign out_vld = vld_r[DIV_STEPS-1];
  assign out_stg = stg_r[DIV_STEPS-1];

endmodule
`default_nettype wire

>>> hw/rtl/tof_norm.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tof_norm: fixed-point vector normalizer
// scales magnitudes so the largest sits at bit 23, takes the root of the
// sum of squares, divides each component with rounding, clamps, resigns
// ----------------------------------------------------------------------------
module tof_norm (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_vld,
  input  wire tof_pkg::vec_comp_t   vec [3],
  output logic                      out_vld,
  output tof_pkg::unit_t            unit [3],
  output logic                      zero_vec
);
  import tof_pkg::*;

  localparam int FRONT_STG = 5;

  function automatic logic [POS_W-1:0] lead_pos(input logic [MAG_W-1:0] v);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) p = POS_W'(i);
    end
    return p;
  endfunction

  logic [FRONT_STG-1:0] fr_vld_r;
  logic                 vld_f_r;

  logic [MAG_W-1:0]  mag_a_nxt [3];
  logic [MAG_W-1:0]  max_a_nxt;
  logic [MAG_W-1:0]  mag_a_r [3];
  logic [MAG_W-1:0]  max_a_r;
  logic [2:0]        sgn_a_r;

  logic [POS_W-1:0]  pos_b;
  logic              shr_b_nxt;
  logic [POS_W-1:0]  sft_b_nxt;
  logic [MAG_W-1:0]  mag_b_r [3];
  logic              shr_b_r;
  logic [POS_W-1:0]  sft_b_r;
  side_t             side_b_r;

  logic [SCL_W-1:0]  m_c_nxt [3];
  logic [SCL_W-1:0]  m_c_r [3];
  side_t             side_c_r;

  logic [SQ_W-1:0]   sq_d_r [3];
  logic [SCL_W-1:0]  m_d_r [3];
  side_t             side_d_r;

  logic [SUM_W-1:0]  sum_e;
  sqrt_stg_t         sq_e_nxt;
  sqrt_stg_t         sq_e_r;

  logic              sqrt_vld;
  sqrt_stg_t         sqrt_out;
  div_stg_t          div_f_nxt;
  div_stg_t          div_f_r;

  logic              div_vld;
  div_stg_t          div_out;
  logic [QUO_W-1:0]  q_clamp;

  // magnitudes and their maximum
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_a_nxt[i] = vec[i][VEC_W-1] ? MAG_W'(~vec[i]) + MAG_W'(1) : MAG_W'(vec[i]);
    end
    max_a_nxt = mag_a_nxt[0];
    if (mag_a_nxt[1] > max_a_nxt) max_a_nxt = mag_a_nxt[1];
    if (mag_a_nxt[2] > max_a_nxt) max_a_nxt = mag_a_nxt[2];
  end

  // shift direction and amount from the leading one
  always_comb begin
    pos_b     = lead_pos(max_a_r);
    shr_b_nxt = pos_b >= POS_W'(SCL_TOP);
    sft_b_nxt = shr_b_nxt ? pos_b - POS_W'(SCL_TOP) : POS_W'(SCL_TOP) - pos_b;
  end

  // common scaling, right shifts truncate
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m_c_nxt[i] = shr_b_r ? SCL_W'(mag_b_r[i] >> sft_b_r) : SCL_W'(mag_b_r[i] << sft_b_r);
    end
  end

  // sum of squares into the root radicand
  always_comb begin
    sum_e         = SUM_W'(sq_d_r[0]) + SUM_W'(sq_d_r[1]) + SUM_W'(sq_d_r[2]);
    sq_e_nxt.rem  = {sum_e, {RAD_SH{1'b0}}};
    sq_e_nxt.root = '0;
    for (int i = 0; i < 3; i++) begin
      sq_e_nxt.mag[i] = m_d_r[i];
    end
    sq_e_nxt.side = side_d_r;
  end

  // front valid chain and divider entry valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= '0;
      vld_f_r  <= 1'b0;
    end else if (en) begin
      fr_vld_r <= {fr_vld_r[FRONT_STG-2:0], in_vld};
      vld_f_r  <= sqrt_vld;
    end
  end

  // front payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      mag_a_r       <= mag_a_nxt;
      max_a_r       <= max_a_nxt;
      for (int i = 0; i < 3; i++) begin
        sgn_a_r[i] <= vec[i][VEC_W-1];
      end
      mag_b_r       <= mag_a_r;
      shr_b_r       <= shr_b_nxt;
      sft_b_r       <= sft_b_nxt;
      side_b_r.sgn  <= sgn_a_r;
      side_b_r.zero <= max_a_r == '0;
      m_c_r         <= m_c_nxt;
      side_c_r      <= side_b_r;
      for (int i = 0; i < 3; i++) begin
        sq_d_r[i] <= SQ_W'(m_c_r[i]) * SQ_W'(m_c_r[i]);
      end
      m_d_r         <= m_c_r;
      side_d_r      <= side_c_r;
      sq_e_r        <= sq_e_nxt;
      div_f_r       <= div_f_nxt;
    end
  end

  tof_sqrt_pipe u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (fr_vld_r[FRONT_STG-1]),
    .in_stg  (sq_e_r),
    .out_vld (sqrt_vld),
    .out_stg (sqrt_out)
  );

  // rounded numerators: m * 2^20 + root / 2
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      div_f_nxt.rem[j] = (NUM_W'(sqrt_out.mag[j]) << NUM_SH)
                       + NUM_W'(sqrt_out.root[ROOT_W-1:1]);
      div_f_nxt.quo[j] = '0;
    end
    div_f_nxt.den  = sqrt_out.root[ROOT_W-1:0];
    div_f_nxt.side = sqrt_out.side;
  end

  tof_div_pipe u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vld_f_r),
    .in_stg  (div_f_r),
    .out_vld (div_vld),
    .out_stg (div_out)
  );

  // clamp to one, restore signs, zero vector gives zero
  always_comb begin
    q_clamp = '0;
    for (int j = 0; j < 3; j++) begin
      q_clamp = (div_out.quo[j] > QUO_W'(UNIT_ONE)) ? QUO_W'(UNIT_ONE) : div_out.quo[j];
      if (div_out.side.zero) begin
        unit[j] = '0;
      end else if (div_out.side.sgn[j]) begin
        unit[j] = unit_t'(-q_clamp);
      end else begin
        unit[j] = unit_t'(q_clamp);
      end
    end
  end

  assign out_vld  = div_vld;
  assign zero_vec = div_out.side.zero;

endmodule
`default_nettype wire

>>> hw/rtl/triangle_orthonormal_frame_core.sv
// Throughput: one triangle per clock while the output is not stalled; every stage is a pipeline register, the
// depth is set by the 31-stage square root and the 16-stage divider.
// A stalled output freezes the whole pipeline in place, nothing is dropped.
// Reset (rst_n low, synchronous) clears the valid bits only; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_orthonormal_frame_core: tangent, bitangent, normal of a triangle
// edge differences and cross products, then three parallel normalizers
// ----------------------------------------------------------------------------
module triangle_orthonormal_frame_core (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // corner0_x, corner0_y, corner0_z, corner1_x .. corner1_z, corner2_x .. corner2_z
  input  wire logic [tof_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // tangent_x/y/z, bitangent_x/y/z, normal_x/y/z
  output logic [tof_pkg::OUT_DATA_W-1:0]       out_tdata,
  // degenerate
  output logic                                 out_tuser
);
  import tof_pkg::*;

  logic                  pipe_en;
  coord_t                c0 [3], c1 [3], c2 [3];
  logic                  crs_vld;
  edge_t                 e_vec [3];
  nrm_t                  n_vec [3];
  vec_comp_t             b_vec [3];
  vec_comp_t             e_ext [3], n_ext [3];
  logic                  t_vld, n_vld, b_vld;
  unit_t                 ut [3], un [3], ub [3];
  logic                  t_zero, n_zero, b_zero;
  logic [OUT_DATA_W-1:0] data_nxt;

  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_tuser_r;

  // whole pipeline advances while the output register is free or taken
  assign pipe_en   = ~out_tvalid_r | out_tready;
  assign in_tready = pipe_en;

  // unpack corners
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c0[i] = coord_t'(in_tdata[COORD_W*i +: COORD_W]);
      c1[i] = coord_t'(in_tdata[COORD_W*(3+i) +: COORD_W]);
      c2[i] = coord_t'(in_tdata[COORD_W*(6+i) +: COORD_W]);
    end
  end

  tof_cross u_cross (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_vld  (in_tvalid),
    .c0      (c0),
    .c1      (c1),
    .c2      (c2),
    .out_vld (crs_vld),
    .e_out   (e_vec),
    .n_out   (n_vec),
    .b_out   (b_vec)
  );

  // sign extend to the normalizer width
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_ext[i] = VEC_W'(e_vec[i]);
      n_ext[i] = VEC_W'(n_vec[i]);
    end
  end

  tof_norm u_norm_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (crs_vld),
    .vec      (e_ext),
    .out_vld  (t_vld),
    .unit     (ut),
    .zero_vec (t_zero)
  );

  tof_norm u_norm_n (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (crs_vld),
    .vec      (n_ext),
    .out_vld  (n_vld),
    .unit     (un),
    .zero_vec (n_zero)
  );

  tof_norm u_norm_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (crs_vld),
    .vec      (b_vec),
    .out_vld  (b_vld),
    .unit     (ub),
    .zero_vec (b_zero)
  );

  // pack result, bitangent is the negated unit of e x n
  always_comb begin
    data_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      data_nxt[UNIT_W*i +: UNIT_W]     = ut[i];
      data_nxt[UNIT_W*(3+i) +: UNIT_W] = unit_t'(-ub[i]);
      data_nxt[UNIT_W*(6+i) +: UNIT_W] = un[i];
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (pipe_en) begin
      out_tvalid_r <= t_vld;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_tdata_r <= data_nxt;
      out_tuser_r <= t_zero | n_zero | b_zero;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // three normalizers run in lockstep
  a_norm_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (t_vld == n_vld) && (n_vld == b_vld))
    else $error("normalizer valids out of step");

  // a frame without the degenerate flag has a nonzero tangent
  a_tangent_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |->
      (out_tdata[UNIT_W-1:0] != '0) || (out_tdata[2*UNIT_W-1:UNIT_W] != '0) ||
      (out_tdata[3*UNIT_W-1:2*UNIT_W] != '0))
    else $error("nondegenerate frame with zero tangent");

  // an all-zero normal is always flagged
  a_zero_normal_flagged: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[7*UNIT_W-1:6*UNIT_W] == '0) &&
     (out_tdata[8*UNIT_W-1:7*UNIT_W] == '0) &&
     (out_tdata[9*UNIT_W-1:8*UNIT_W] == '0)) |-> out_tuser)
    else $error("zero normal without degenerate flag");

  // the tangent x component stays within plus and minus one
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (unit_t'(out_tdata[UNIT_W-1:0]) <= unit_t'(UNIT_ONE)) &&
      (unit_t'(out_tdata[UNIT_W-1:0]) >= unit_t'(-UNIT_ONE)))
    else $error("tangent x outside unit range");

endmodule
`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for triangle_orthonormal_frame_core
// streams triangles in bursts, predicts each frame in fixed point, and
// checks every frame in order under random output back-pressure
// ----------------------------------------------------------------------------

// in-order store of predicted frames
class frame_board;
  logic [tof_pkg::OUT_DATA_W-1:0] frame_q[$];
  logic                           degen_q[$];
  int                             errors;
  int                             checked;

  function new();
    errors  = 0;
    checked = 0;
  endfunction

  // remember the frame predicted for one accepted triangle
  function void note_request(logic [tof_pkg::OUT_DATA_W-1:0] frame, logic degen);
    frame_q.push_back(frame);
    degen_q.push_back(degen);
  endfunction

  // compare one delivered frame against the oldest prediction
  function void check_frame(logic [tof_pkg::OUT_DATA_W-1:0] frame, logic degen);
    logic [tof_pkg::OUT_DATA_W-1:0] want;
    logic                           want_deg;
    if (frame_q.size() == 0) begin
      $display("%0t: unexpected frame %h deg %b", $time, frame, degen);
      errors++;
      return;
    end
    want     = frame_q.pop_front();
    want_deg = degen_q.pop_front();
    checked++;
    for (int i = 0; i < 9; i++) begin
      if (want[i*16 +: 16] !== frame[i*16 +: 16]) begin
        $display("%0t: component %0d expected %0d actual %0d", $time, i,
                 $signed(want[i*16 +: 16]), $signed(frame[i*16 +: 16]));
        errors++;
      end
    end
    if (want_deg !== degen) begin
      $display("%0t: degenerate expected %b actual %b", $time, want_deg, degen);
      errors++;
    end
  endfunction
endclass

module tb;
  import tof_pkg::*;

  localparam int LATENCY   = 59;
  localparam int CYCLE_CAP = 400000;
  localparam int N_RANDOM  = 1800;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_DATA_W-1:0]   in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_DATA_W-1:0]  out_tdata;
  logic                   out_tuser;

  frame_board board;
  int         cycles;
  bit         hold_off_req;
  int         n_sent;
  int         n_degen;

  triangle_orthonormal_frame_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // frame predictor
  // ---------------------------------------------------------------------------

  function automatic longint unsigned abs64(longint v);
    return v < 0 ? longint'(-v) : longint'(v);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x  -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // magnitudes shifted down together until each is below 2^17
  function automatic void shrink_dir(ref longint v[3]);
    longint unsigned m[3];
    for (int i = 0; i < 3; i++) m[i] = abs64(v[i]);
    while (m[0] >= 2**17 || m[1] >= 2**17 || m[2] >= 2**17)
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    for (int i = 0; i < 3; i++) v[i] = v[i] < 0 ? -longint'(m[i]) : longint'(m[i]);
  endfunction

  // unit vector in Q1.14; returns 1 for a zero vector
  function automatic bit to_unit(longint v[3], ref longint u[3]);
    longint unsigned m[3], mx, s, d, q;
    for (int i = 0; i < 3; i++) m[i] = abs64(v[i]);
    mx = m[0];
    if (m[1] > mx) mx = m[1];
    if (m[2] > mx) mx = m[2];
    if (mx == 0) begin
      for (int i = 0; i < 3; i++) u[i] = 0;
      return 1'b1;
    end
    while (mx >= 64'd1 << 24) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) m[i] >>= 1;
    end
    while (mx < 64'd1 << 23) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) m[i] <<= 1;
    end
    s = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
    d = root_floor(s << 12);
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << (UNIT_FRAC + 6)) + (d >> 1)) / d;
      if (q > UNIT_ONE) q = UNIT_ONE;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b0;
  endfunction

  function automatic void predict_frame(logic [IN_DATA_W-1:0] tri_in,
                                        output logic [OUT_DATA_W-1:0] frame,
                                        output logic degen);
    longint c[9], e[3], t[3], n[3], b[3], ut[3], un[3], ub[3];
    for (int i = 0; i < 9; i++) c[i] = longint'(coord_t'(tri_in[i*COORD_W +: COORD_W]));
    for (int i = 0; i < 3; i++) begin
      e[i] = c[3+i] - c[i];
      t[i] = c[6+i] - c[i];
    end
    shrink_dir(e);
    shrink_dir(t);
    n[0] = e[1]*t[2] - e[2]*t[1];
    n[1] = e[2]*t[0] - e[0]*t[2];
    n[2] = e[0]*t[1] - e[1]*t[0];
    b[0] = e[1]*n[2] - e[2]*n[1];
    b[1] = e[2]*n[0] - e[0]*n[2];
    b[2] = e[0]*n[1] - e[1]*n[0];
    degen = 1'b0;
    degen |= to_unit(e, ut);
    degen |= to_unit(n, un);
    degen |= to_unit(b, ub);
    frame = '0;
    for (int i = 0; i < 3; i++) begin
      frame[i*UNIT_W +: UNIT_W]     = unit_t'(ut[i]);
      frame[(3+i)*UNIT_W +: UNIT_W] = unit_t'(-ub[i]);
      frame[(6+i)*UNIT_W +: UNIT_W] = unit_t'(un[i]);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------

  function automatic logic [IN_DATA_W-1:0] pack_tri(int c[9]);
    logic [IN_DATA_W-1:0] r;
    r = '0;
    for (int i = 0; i < 9; i++) r[i*COORD_W +: COORD_W] = coord_t'(c[i]);
    return r;
  endfunction

  // offer one triangle and wait for it to be taken
  task automatic send_tri(logic [IN_DATA_W-1:0] tri_in);
    in_tvalid <= 1'b1;
    in_tdata  <= tri_in;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic idle_input(int n);
    in_tvalid <= 1'b0;
    in_tdata  <= {IN_DATA_W{1'b0}};
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_wait();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.frame_q.size() != 0) @(posedge clk);
  endtask

  function automatic int rnd_coord(int mode);
    case (mode)
      0: return $urandom_range(0, 65535) - 32768;
      1: return $urandom_range(0, 2047) - 1024;
      2: return $urandom_range(0, 1) ? 32767 - $urandom_range(0, 7)
                                      : -32768 + $urandom_range(0, 7);
      default: return $urandom_range(0, 15) - 8;
    endcase
  endfunction

  task automatic directed_part();
    int c[9];
    int k;
    // zero edge: all corners equal
    c = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_tri(pack_tri(c));
    c = '{-32768, 32767, 5, -32768, 32767, 5, 100, 200, 300};
    send_tri(pack_tri(c));
    // collinear corners
    c = '{0, 0, 0, 256, 0, 0, 512, 0, 0};
    send_tri(pack_tri(c));
    c = '{10, 20, 30, 20, 40, 60, 40, 80, 120};
    send_tri(pack_tri(c));
    // third corner equal to first
    c = '{1, 2, 3, 4, 5, 6, 1, 2, 3};
    send_tri(pack_tri(c));
    // axis-aligned unit triangles
    c = '{0, 0, 0, 256, 0, 0, 0, 256, 0};
    send_tri(pack_tri(c));
    c = '{0, 0, 0, 0, 0, -256, 0, 256, 0};
    send_tri(pack_tri(c));
    // extreme spans, widest differences
    c = '{-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768, 32767};
    send_tri(pack_tri(c));
    c = '{32767, 32767, 32767, -32768, -32768, -32768, -32768, 32767, -32768};
    send_tri(pack_tri(c));
    c = '{-32768, 0, 0, 32767, 0, 0, 0, 32767, 0};
    send_tri(pack_tri(c));
    c = '{0, -32768, 0, 0, 32767, 0, 0, 0, -32768};
    send_tri(pack_tri(c));
    // tiny triangles
    c = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
    send_tri(pack_tri(c));
    c = '{-1, -1, -1, 0, -1, -1, -1, -1, 0};
    send_tri(pack_tri(c));
    c = '{5, 5, 5, 6, 6, 6, 5, 6, 5};
    send_tri(pack_tri(c));
    // all-ones and alternating bit patterns
    c = '{-1, -1, -1, 21845, -21846, 21845, -21846, 21845, -21846};
    send_tri(pack_tri(c));
    for (k = 0; k < 4; k++) begin
      for (int i = 0; i < 9; i++) c[i] = rnd_coord(k);
      send_tri(pack_tri(c));
    end
  endtask

  task automatic random_part();
    int c[9];
    int burst, mode;
    int left;
    left = N_RANDOM;
    while (left > 0) begin
      burst = $urandom_range(1, 40);
      if (burst > left) burst = left;
      for (int b = 0; b < burst; b++) begin
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 9; i++) c[i] = rnd_coord(mode < 5 ? 0 : mode < 7 ? 1 : mode - 6);
        // sometimes force a degenerate shape
        if ($urandom_range(0, 19) == 0) for (int i = 0; i < 3; i++) c[3+i] = c[i];
        else if ($urandom_range(0, 19) == 0)
          for (int i = 0; i < 3; i++) c[6+i] = c[i] + 2 * (c[3+i] - c[i]) / 2;
        send_tri(pack_tri(c));
        left--;
      end
      if ($urandom_range(0, 2) != 0) idle_input($urandom_range(1, 12));
      if (left == N_RANDOM / 2) drain_wait();
    end
  endtask

  // record every accepted triangle
  always @(posedge clk) begin
    logic [OUT_DATA_W-1:0] f;
    logic                  dg;
    if (rst_n && in_tvalid && in_tready) begin
      predict_frame(in_tdata, f, dg);
      board.note_request(f, dg);
      if (dg) n_degen++;
    end
  end

  // check every delivered frame
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_frame(out_tdata, out_tuser);
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int phase;
    out_tready <= 1'b0;
    @(posedge clk);
    while (1) begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off_req = 1'b0;
      end
      phase = $urandom_range(0, 3);
      for (int i = 0; i < 32; i++) begin
        case (phase)
          0: out_tready <= 1'b1;
          1: out_tready <= ($urandom_range(0, 3) != 0);
          2: out_tready <= ($urandom_range(0, 1) != 0);
          default: out_tready <= (i % 4 != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_CAP) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles", cycles);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    int waited;
    board        = new();
    hold_off_req = 1'b0;
    n_sent       = 0;
    n_degen      = 0;
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= {IN_DATA_W{1'b0}};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_part();
    drain_wait();

    // long receiver hold-off while triangles keep coming
    hold_off_req = 1'b1;
    random_part();

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.frame_q.size() != 0) @(posedge clk);
    waited = 0;
    while (waited < 2 * LATENCY) begin
      @(posedge clk);
      waited++;
    end

    $display("sent %0d triangles, %0d frames checked, %0d degenerate",
             n_sent, board.checked, n_degen);
    $display("covered zero edges, collinear corners, full-scale spans and stalls");
    if (board.errors == 0 && board.frame_q.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end
endmodule
